### rtl/drrip_pkg.sv
`default_nettype none

package drrip_pkg;

  typedef enum logic [0:0] {
    CMD_QUERY  = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESOLVE,
    ST_EXEC
  } state_e;

  localparam logic [1:0] RRPV_NEAR = 2'd0;
  localparam logic [1:0] RRPV_LONG = 2'd2;
  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [1:0] STRIDE_SAT = 2'd3;

  typedef struct packed {
    cmd_e        command;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic [63:0] phys_addr;
    logic        was_hit;
    logic [4:0]  rand_draw;
  } in_item_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       set_streaming;
    logic [9:0] selector_now;
  } out_item_t;

  // Per-set stream detector record
  typedef struct packed {
    logic [1:0]  stride;
    logic [63:0] prev_miss_addr;
    logic        stream;
  } set_rec_t;

  // Control for the per-way row update
  typedef struct packed {
    logic       query;
    logic       hit;
    logic       way_ok;
    logic [3:0] way;
    logic [1:0] ins;
  } way_op_t;

endpackage

`default_nettype wire

### rtl/drrip_way_logic.sv
`default_nettype none

module drrip_way_logic #(
  parameter int NUM_WAYS = 16
) (
  input  wire logic [NUM_WAYS-1:0][1:0] rrpv_i,
  input  wire logic [NUM_WAYS-1:0]      dead_i,
  input  wire drrip_pkg::way_op_t       op_i,
  output logic      [NUM_WAYS-1:0][1:0] rrpv_o,
  output logic      [NUM_WAYS-1:0]      dead_o,
  output logic      [3:0]               victim_o
);

  logic [4:0] dead_way;
  logic [4:0] top_way;
  logic       any_dead;
  logic [3:0] has_val;
  logic [1:0] top;
  logic [1:0] age;

  always_comb begin
    dead_way = '0;
    any_dead = 1'b0;
    has_val  = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (dead_i[w]) begin
        dead_way = 5'(w);
        any_dead = 1'b1;
      end
      has_val[rrpv_i[w]] = 1'b1;
    end
    priority if (has_val[3]) top = 2'd3;
    else if (has_val[2]) top = 2'd2;
    else if (has_val[1]) top = 2'd1;
    else top = 2'd0;
    age = drrip_pkg::RRPV_MAX - top;
    top_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (rrpv_i[w] == top) top_way = 5'(w);
    end
  end

  always_comb begin
    rrpv_o   = rrpv_i;
    dead_o   = dead_i;
    victim_o = '0;
    if (op_i.query) begin
      if (any_dead) begin
        victim_o = dead_way[3:0];
      end else begin
        victim_o = top_way[3:0];
        for (int w = 0; w < NUM_WAYS; w++) rrpv_o[w] = rrpv_i[w] + age;
      end
    end else if (op_i.way_ok) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (6'(w) == {2'b00, op_i.way}) begin
          rrpv_o[w] = op_i.hit ? drrip_pkg::RRPV_NEAR : op_i.ins;
          dead_o[w] = ~op_i.hit;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/drrip_replacement_stream_bypass.sv
`default_nettype none

// Channel  | Ports                   | Handshake
// ---------+-------------------------+------------------------------------------
// command  | start, busy, in_i       | item taken at clk edge with start & !busy
// result   | done_o, result_o        | one cycle strobe, receiver cannot stall
//
// Each item goes through a reciprocal multiply that reduces the set index,
// the row read of the set memories, then modify and write back. The result
// shows the cycle after write back, when the next item may be taken.
// After reset a clearing pass writes every set row with busy held high.
// Rows are never read while their write is outstanding, so no forwarding
// is needed.

module drrip_replacement_stream_bypass #(
  parameter int NUM_SETS      = 2048,
  parameter int NUM_WAYS      = 16,
  parameter int LEADER_SETS   = 32,
  parameter int SELECTOR_BITS = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire drrip_pkg::in_item_t  in_i,
  output logic                      done_o,
  output drrip_pkg::out_item_t      result_o
);

  localparam int SW        = $clog2(NUM_SETS);
  localparam int RECIP_SH  = 22;
  localparam int RECIP     = (1 << RECIP_SH) / NUM_SETS;
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX  = {SELECTOR_BITS{1'b1}};
  localparam logic [SELECTOR_BITS-1:0] SEL_HALF = SEL_MAX >> 1;

  drrip_pkg::state_e state_q, state_d;
  drrip_pkg::in_item_t in_q;
  logic [10:0] quot_q;
  logic [SW-1:0] set_q, set_d;
  logic [SW-1:0] clr_q;
  logic [SELECTOR_BITS-1:0] sel_q, sel_d;
  logic done_q;
  drrip_pkg::out_item_t res_q, res_d;

  // Set memories
  logic [NUM_WAYS*3-1:0] way_mem [NUM_SETS];
  drrip_pkg::set_rec_t   set_mem [NUM_SETS];
  logic [NUM_WAYS*3-1:0] way_rd_q, way_wr;
  drrip_pkg::set_rec_t   set_rd_q, set_wr;
  logic                  mem_rd, mem_wr;
  logic [SW-1:0]         wr_addr;

  // Reduce the set index: quotient by reciprocal, remainder with one correction
  logic [33:0] recip_prod;
  logic [27:0] quot_n, rem;

  assign recip_prod = 34'(in_i.set_index) * 34'(RECIP);

  always_comb begin
    quot_n = 28'(quot_q) * 28'(NUM_SETS);
    rem    = 28'(in_q.set_index) - quot_n;
    if (rem >= 28'(NUM_SETS)) rem = rem - 28'(NUM_SETS);
    set_d = SW'(rem);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drrip_pkg::ST_CLEAR:   if (clr_q == SW'(NUM_SETS - 1)) state_d = drrip_pkg::ST_IDLE;
      drrip_pkg::ST_IDLE:    if (start) state_d = drrip_pkg::ST_RESOLVE;
      drrip_pkg::ST_RESOLVE: state_d = drrip_pkg::ST_EXEC;
      drrip_pkg::ST_EXEC:    state_d = drrip_pkg::ST_IDLE;
      default:               state_d = drrip_pkg::ST_IDLE;
    endcase
  end

  // Row modify
  logic miss, srrip_lead, brrip_lead, use_srrip;
  logic [1:0] stride_n, ins;
  logic flag_n;
  drrip_pkg::set_rec_t rec_n;
  drrip_pkg::way_op_t way_op;
  logic [NUM_WAYS-1:0][1:0] rrpv_rd, rrpv_wr;
  logic [NUM_WAYS-1:0]      dead_rd, dead_wr;
  logic [3:0] victim;

  assign rrpv_rd = way_rd_q[NUM_WAYS*2-1:0];
  assign dead_rd = way_rd_q[NUM_WAYS*3-1:NUM_WAYS*2];

  always_comb begin
    miss       = (in_q.command == drrip_pkg::CMD_UPDATE) && !in_q.was_hit;
    srrip_lead = {1'b0, set_q} < (SW+1)'(LEADER_SETS / 2);
    brrip_lead = !srrip_lead && ({1'b0, set_q} < (SW+1)'(LEADER_SETS));
    // Stream detector: zero last address means unset
    if (set_rd_q.prev_miss_addr == 64'd0) begin
      stride_n = 2'd0;
    end else if (in_q.phys_addr > set_rd_q.prev_miss_addr) begin
      stride_n = (set_rd_q.stride == drrip_pkg::STRIDE_SAT) ? set_rd_q.stride
                                                           : set_rd_q.stride + 2'd1;
    end else begin
      stride_n = (set_rd_q.stride == 2'd0) ? 2'd0 : set_rd_q.stride - 2'd1;
    end
    flag_n = (stride_n == drrip_pkg::STRIDE_SAT);
    use_srrip = srrip_lead || (!brrip_lead && (sel_q >= SEL_HALF));
    priority if (flag_n) ins = drrip_pkg::RRPV_MAX;
    else if (use_srrip || in_q.rand_draw == 5'd0) ins = drrip_pkg::RRPV_LONG;
    else ins = drrip_pkg::RRPV_MAX;

    rec_n = set_rd_q;
    sel_d = sel_q;
    if (miss) begin
      rec_n.stride         = stride_n;
      rec_n.prev_miss_addr = in_q.phys_addr;
      rec_n.stream         = flag_n;
      // Train the selector on non-streaming leader misses
      if (!flag_n) begin
        if (srrip_lead && sel_q != '0) sel_d = sel_q - 1'b1;
        else if (brrip_lead && sel_q != SEL_MAX) sel_d = sel_q + 1'b1;
      end
    end

    way_op.query  = (in_q.command == drrip_pkg::CMD_QUERY);
    way_op.hit    = in_q.was_hit;
    way_op.way_ok = {2'b00, in_q.way_index} < 6'(NUM_WAYS);
    way_op.way    = in_q.way_index;
    way_op.ins    = ins;
  end

  drrip_way_logic #(
    .NUM_WAYS (NUM_WAYS)
  ) u_way (
    .rrpv_i   (rrpv_rd),
    .dead_i   (dead_rd),
    .op_i     (way_op),
    .rrpv_o   (rrpv_wr),
    .dead_o   (dead_wr),
    .victim_o (victim)
  );

  // Outputs and memory control
  logic [25:0] sel_ext;

  always_comb begin
    busy    = (state_q != drrip_pkg::ST_IDLE);
    mem_rd  = (state_q == drrip_pkg::ST_RESOLVE);
    mem_wr  = (state_q == drrip_pkg::ST_CLEAR) || (state_q == drrip_pkg::ST_EXEC);
    sel_ext = 26'(sel_d);
    if (state_q == drrip_pkg::ST_CLEAR) begin
      wr_addr = clr_q;
      way_wr  = {{NUM_WAYS{1'b0}}, {NUM_WAYS{drrip_pkg::RRPV_MAX}}};
      set_wr  = '0;
    end else begin
      wr_addr = set_q;
      way_wr  = {dead_wr, rrpv_wr};
      set_wr  = rec_n;
    end
    res_d.victim_way    = way_op.query ? victim : 4'd0;
    res_d.set_streaming = miss ? flag_n : set_rd_q.stream;
    res_d.selector_now  = sel_ext[9:0];
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  always_ff @(posedge clk_i) begin
    if (mem_rd) begin
      way_rd_q <= way_mem[set_d];
      set_rd_q <= set_mem[set_d];
    end
    if (mem_wr) begin
      way_mem[wr_addr] <= way_wr;
      set_mem[wr_addr] <= set_wr;
    end
  end

  // Hold the item and its reduced set index
  always_ff @(posedge clk_i) begin
    if (state_q == drrip_pkg::ST_IDLE && start) begin
      in_q   <= in_i;
      quot_q <= 11'(recip_prod >> RECIP_SH);
    end
    if (state_q == drrip_pkg::ST_RESOLVE) set_q <= set_d;
    if (state_q == drrip_pkg::ST_EXEC) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drrip_pkg::ST_CLEAR;
      clr_q   <= '0;
      sel_q   <= SEL_HALF;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == drrip_pkg::ST_EXEC);
      if (state_q == drrip_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == drrip_pkg::ST_EXEC) sel_q <= sel_d;
    end
  end

endmodule

`default_nettype wire
